FILE: hdl/rlcs_pkg.sv
`timescale 1ns / 1ps
package rlcs_pkg;

  // Default sizing
  localparam int MAX_ROWS_DEF         = 1024;
  localparam int MAX_ROW_NONZEROS_DEF = 256;
  localparam int OFFSET_BITS_DEF      = 20;

  // Request codes
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_PERM  = 2'd1;
  localparam logic [1:0] FN_GROUP = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_LOAD_ERR = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // request taken this cycle
    logic start;       // begin a sort pass
    logic put_direct;  // result that needs no memory data
    logic put_mem;     // result built from read data
    logic put_done;    // result of a finished sort pass
    logic k_clr;
    logic k_inc;
    logic clr;         // clear one bucket count
    logic h_rd;        // histogram: read row length
    logic h_cnt;       // histogram: read bucket count
    logic h_wr;        // histogram: write incremented count
    logic p_rd;        // prefix: read bucket count
    logic p_wr;        // prefix: write fill start and group record
    logic p_end;       // prefix: write closing group entry
    logic s_rd;        // scatter: read row length
    logic s_fill;      // scatter: read bucket fill position
    logic s_wr;        // scatter: write permutation entry
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic direct;      // request is answered without memory data
    logic out_free;
    logic k_last_row;
    logic k_last_bkt;
    logic rows_zero;
  } sts_t;

endpackage

FILE: hdl/rlcs_in_if.sv
`timescale 1ns / 1ps
interface rlcs_in_if #(
  parameter int OFFSET_W = 20,
  parameter int INDEX_W  = 11
);
  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [OFFSET_W-1:0] row_offset;
  logic                final_offset;
  logic [INDEX_W-1:0]  read_index;

  modport source (output valid, func, row_offset, final_offset, read_index, input ready);
  modport sink   (input valid, func, row_offset, final_offset, read_index, output ready);
endinterface

FILE: hdl/rlcs_out_if.sv
`timescale 1ns / 1ps
interface rlcs_out_if #(
  parameter int ROW_W = 10,
  parameter int LEN_W = 9,
  parameter int CNT_W = 11,
  parameter int GT_W  = 9
);
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_number;
  logic [LEN_W-1:0] group_length;
  logic [CNT_W-1:0] group_begin;
  logic [GT_W-1:0]  groups_total;
  logic [1:0]       status;

  modport source (output valid, row_number, group_length, group_begin, groups_total, status,
                  input ready);
  modport sink   (input valid, row_number, group_length, group_begin, groups_total, status,
                  output ready);
endinterface

FILE: hdl/rlcs_ctrl.sv
`timescale 1ns / 1ps
module rlcs_ctrl
  import rlcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  input  logic       in_final,
  output logic       in_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [12:0] {
    S_IDLE = 13'h0001,
    S_RESP = 13'h0002,
    S_CLR  = 13'h0004,
    S_HRD  = 13'h0008,
    S_HCNT = 13'h0010,
    S_HWR  = 13'h0020,
    S_PRD  = 13'h0040,
    S_PWR  = 13'h0080,
    S_PEND = 13'h0100,
    S_SRD  = 13'h0200,
    S_SFIL = 13'h0400,
    S_SWR  = 13'h0800,
    S_DONE = 13'h1000
  } state_t;

  state_t state_r, state_nxt;

  // Sequence requests and sort passes
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.accept = 1'b1;
          case (in_func)
            FN_LOAD: begin
              if (in_final) begin
                if (sts.direct) begin
                  cmd.put_direct = 1'b1;
                end else begin
                  cmd.start = 1'b1;
                  cmd.k_clr = 1'b1;
                  state_nxt = S_CLR;
                end
              end
            end
            FN_PERM, FN_GROUP: begin
              if (sts.direct) cmd.put_direct = 1'b1;
              else            state_nxt = S_RESP;
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        cmd.put_mem = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.k_last_bkt) begin
          cmd.k_clr = 1'b1;
          state_nxt = sts.rows_zero ? S_PRD : S_HRD;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_HRD: begin
        cmd.h_rd  = 1'b1;
        state_nxt = S_HCNT;
      end
      S_HCNT: begin
        cmd.h_cnt = 1'b1;
        state_nxt = S_HWR;
      end
      S_HWR: begin
        cmd.h_wr = 1'b1;
        if (sts.k_last_row) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_PRD;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_HRD;
        end
      end
      S_PRD: begin
        cmd.p_rd  = 1'b1;
        state_nxt = S_PWR;
      end
      S_PWR: begin
        cmd.p_wr = 1'b1;
        if (sts.k_last_bkt) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_PEND;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_PEND: begin
        cmd.p_end = 1'b1;
        state_nxt = sts.rows_zero ? S_DONE : S_SRD;
      end
      S_SRD: begin
        cmd.s_rd  = 1'b1;
        state_nxt = S_SFIL;
      end
      S_SFIL: begin
        cmd.s_fill = 1'b1;
        state_nxt  = S_SWR;
      end
      S_SWR: begin
        cmd.s_wr = 1'b1;
        if (sts.k_last_row) begin
          state_nxt = S_DONE;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_DONE: begin
        cmd.put_done = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_put_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.put_direct || cmd.put_mem || cmd.put_done) |-> sts.out_free)
    else $error("result written while output register is occupied");
  a_put_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.put_direct, cmd.put_mem, cmd.put_done}))
    else $error("more than one result source in a cycle");
  a_start_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == S_CLR)
    else $error("sort pass did not begin with the count clear");
  a_resp_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP |=> state_r == S_IDLE)
    else $error("read response held more than one cycle");
`endif

endmodule

FILE: hdl/rlcs_dp.sv
`timescale 1ns / 1ps
module rlcs_dp
  import rlcs_pkg::*;
#(
  parameter int MAX_ROWS         = MAX_ROWS_DEF,
  parameter int MAX_ROW_NONZEROS = MAX_ROW_NONZEROS_DEF,
  parameter int OFFSET_BITS      = OFFSET_BITS_DEF,
  localparam int NB    = MAX_ROW_NONZEROS + 1,
  localparam int ROW_W = $clog2(MAX_ROWS),
  localparam int CNT_W = $clog2(MAX_ROWS + 1),
  localparam int LEN_W = $clog2(NB),
  localparam int GT_W  = $clog2(NB + 1)
)(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [1:0]             in_func,
  input  logic [OFFSET_BITS-1:0] in_row_offset,
  input  logic                   in_final,
  input  logic [CNT_W-1:0]       in_read_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ROW_W-1:0]       out_row_number,
  output logic [LEN_W-1:0]       out_group_length,
  output logic [CNT_W-1:0]       out_group_begin,
  output logic [GT_W-1:0]        out_groups_total,
  output logic [1:0]             out_status
);

  localparam int KW = (CNT_W > GT_W) ? CNT_W : GT_W;

  typedef enum logic [1:0] {RS_PERM, RS_GROUP, RS_END} rsel_t;

  // Load and build state
  logic [OFFSET_BITS-1:0] prev_off_r;
  logic [CNT_W-1:0]       rows_r, rows_nxt;
  logic [GT_W-1:0]        tally_r, n_r;
  logic [CNT_W-1:0]       pos_r;
  logic [KW-1:0]          k_r;
  logic                   built_r, err_r, open_r, err_nxt;
  rsel_t                  rsel_r, rsel_nxt;

  // Memories and their read registers
  logic [LEN_W-1:0] len_mem   [MAX_ROWS];
  logic [CNT_W-1:0] cnt_mem   [NB];
  logic [CNT_W-1:0] fill_mem  [NB];
  logic [ROW_W-1:0] perm_mem  [MAX_ROWS];
  logic [LEN_W-1:0] glen_mem  [NB];
  logic [CNT_W-1:0] gstart_mem[NB + 1];
  logic [LEN_W-1:0] len_q, glen_q;
  logic [CNT_W-1:0] cnt_q, fill_q, gstart_q;
  logic [ROW_W-1:0] perm_q;

  // Output register
  logic             out_valid_r;
  logic [ROW_W-1:0] o_row_r, o_row_nxt;
  logic [LEN_W-1:0] o_len_r, o_len_nxt;
  logic [CNT_W-1:0] o_beg_r, o_beg_nxt;
  logic [GT_W-1:0]  o_gt_r, o_gt_nxt;
  logic [1:0]       o_st_r, o_st_nxt;

  logic                   ld, falling, too_long, too_many, store, in_rng, nz;
  logic [OFFSET_BITS-1:0] diff;
  logic [KW-1:0]          idx_w;

  // Classify the incoming request
  always_comb begin
    idx_w    = KW'(in_read_index);
    ld       = cmd.accept && (in_func == FN_LOAD);
    diff     = in_row_offset - prev_off_r;
    falling  = in_row_offset < prev_off_r;
    too_long = 33'(diff) > 33'(MAX_ROW_NONZEROS);
    too_many = rows_r >= CNT_W'(MAX_ROWS);
    store    = ld && open_r && !falling && !too_long && !too_many;
    err_nxt  = open_r ? (err_r | falling | too_long | too_many) : 1'b0;
    rows_nxt = open_r ? (rows_r + CNT_W'(store)) : '0;
    if (in_func == FN_PERM) begin
      in_rng   = idx_w < KW'(rows_r);
      rsel_nxt = RS_PERM;
    end else begin
      in_rng   = idx_w <= KW'(tally_r);
      rsel_nxt = (idx_w == KW'(tally_r)) ? RS_END : RS_GROUP;
    end
    nz = cnt_q != '0;
  end

  assign sts.direct     = (in_func == FN_LOAD) ? (in_final && err_nxt)
                                               : (err_r || !built_r || !in_rng);
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.k_last_row = k_r == (KW'(rows_r) - KW'(1));
  assign sts.k_last_bkt = k_r == KW'(NB - 1);
  assign sts.rows_zero  = rows_r == '0;

  // Select the next result
  always_comb begin
    o_row_nxt = '0;
    o_len_nxt = '0;
    o_beg_nxt = '0;
    o_gt_nxt  = '0;
    o_st_nxt  = ST_OK;
    if (cmd.put_done) begin
      o_beg_nxt = rows_r;
      o_gt_nxt  = tally_r;
    end else if (cmd.put_mem) begin
      o_gt_nxt = tally_r;
      case (rsel_r)
        RS_PERM:  o_row_nxt = perm_q;
        RS_GROUP: begin
          o_len_nxt = glen_q;
          o_beg_nxt = gstart_q;
        end
        default:  o_beg_nxt = gstart_q;
      endcase
    end else if (in_func == FN_LOAD) begin
      o_beg_nxt = rows_nxt;
      o_st_nxt  = ST_LOAD_ERR;
    end else if (err_r) begin
      o_st_nxt = ST_LOAD_ERR;
    end else if (!built_r) begin
      o_st_nxt = ST_RANGE;
    end else begin
      o_gt_nxt = tally_r;
      o_st_nxt = ST_RANGE;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_off_r  <= '0;
      rows_r      <= '0;
      tally_r     <= '0;
      built_r     <= 1'b0;
      err_r       <= 1'b0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      n_r         <= '0;
      pos_r       <= '0;
      rsel_r      <= RS_PERM;
    end else begin
      if (ld) begin
        prev_off_r <= in_row_offset;
        rows_r     <= rows_nxt;
        err_r      <= err_nxt;
        open_r     <= !in_final;
        if (!open_r) begin
          built_r <= 1'b0;
          tally_r <= '0;
        end
      end
      if (cmd.accept) rsel_r <= rsel_nxt;
      if (cmd.k_clr)      k_r <= '0;
      else if (cmd.k_inc) k_r <= k_r + KW'(1);
      if (cmd.start) begin
        n_r   <= '0;
        pos_r <= '0;
      end else if (cmd.p_wr && nz) begin
        n_r   <= n_r + GT_W'(1);
        pos_r <= pos_r + cnt_q;
      end
      if (cmd.p_end) tally_r <= n_r;
      if (cmd.put_done) built_r <= 1'b1;
      if (cmd.put_direct || cmd.put_mem || cmd.put_done) out_valid_r <= 1'b1;
      else if (out_ready)                                out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.put_direct || cmd.put_mem || cmd.put_done) begin
      o_row_r <= o_row_nxt;
      o_len_r <= o_len_nxt;
      o_beg_r <= o_beg_nxt;
      o_gt_r  <= o_gt_nxt;
      o_st_r  <= o_st_nxt;
    end
  end

  // Row lengths
  always_ff @(posedge clk) begin
    if (store) len_mem[rows_r[ROW_W-1:0]] <= diff[LEN_W-1:0];
    if (cmd.h_rd || cmd.s_rd) len_q <= len_mem[k_r[ROW_W-1:0]];
  end

  // Bucket counts: clear, then increment per row
  always_ff @(posedge clk) begin
    if (cmd.clr)       cnt_mem[k_r[LEN_W-1:0]] <= '0;
    else if (cmd.h_wr) cnt_mem[len_q] <= cnt_q + CNT_W'(1);
    if (cmd.h_cnt)     cnt_q <= cnt_mem[len_q];
    else if (cmd.p_rd) cnt_q <= cnt_mem[k_r[LEN_W-1:0]];
  end

  // Bucket fill positions
  always_ff @(posedge clk) begin
    if (cmd.p_wr)      fill_mem[k_r[LEN_W-1:0]] <= pos_r;
    else if (cmd.s_wr) fill_mem[len_q] <= fill_q + CNT_W'(1);
    if (cmd.s_fill)    fill_q <= fill_mem[len_q];
  end

  // Permutation
  always_ff @(posedge clk) begin
    if (cmd.s_wr)   perm_mem[fill_q[ROW_W-1:0]] <= k_r[ROW_W-1:0];
    if (cmd.accept) perm_q <= perm_mem[idx_w[ROW_W-1:0]];
  end

  // Group records
  always_ff @(posedge clk) begin
    if (cmd.p_wr && nz) glen_mem[n_r[LEN_W-1:0]] <= k_r[LEN_W-1:0];
    if ((cmd.p_wr && nz) || cmd.p_end) gstart_mem[n_r] <= pos_r;
    if (cmd.accept) begin
      glen_q   <= glen_mem[idx_w[LEN_W-1:0]];
      gstart_q <= gstart_mem[idx_w[GT_W-1:0]];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_number   = o_row_r;
  assign out_group_length = o_len_r;
  assign out_group_begin  = o_beg_r;
  assign out_groups_total = o_gt_r;
  assign out_status       = o_st_r;

`ifndef SYNTHESIS
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= KW'(NB) || k_r <= KW'(MAX_ROWS))
    else $error("sequence index out of range");
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put_done |-> !err_r && !open_r)
    else $error("sort finished on a failed or open load");
  a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tally_r <= GT_W'(NB))
    else $error("group tally above bucket count");
`endif

endmodule

FILE: hdl/row_length_counting_sort_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// in_if     in   valid/ready    func, row_offset, final_offset, read_index
// out_if    out  valid/ready    row_number, group_length, group_begin, groups_total, status
//
// A load offset is checked when accepted; a read answer is built from a registered memory read.
// The final offset runs the sort: clear the bucket counts, count the row lengths, then a
// prefix pass writes the group records and a scatter pass fills the permutation.
// rst_n is synchronous; row, bucket and permutation memories need no clearing.
// in_if.ready is low while sorting, reading, or while a result waits and out_if.ready is low.
module row_length_counting_sort_top
  import rlcs_pkg::*;
#(
  parameter int MAX_ROWS         = MAX_ROWS_DEF,
  parameter int MAX_ROW_NONZEROS = MAX_ROW_NONZEROS_DEF,
  parameter int OFFSET_BITS      = OFFSET_BITS_DEF
)(
  input logic         clk,
  input logic         rst_n,
  rlcs_in_if.sink     in_if,
  rlcs_out_if.source  out_if
);

  cmd_t cmd;
  sts_t sts;
  logic rdy;

  rlcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_func  (in_if.func),
    .in_final (in_if.final_offset),
    .in_ready (rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  rlcs_dp #(
    .MAX_ROWS         (MAX_ROWS),
    .MAX_ROW_NONZEROS (MAX_ROW_NONZEROS),
    .OFFSET_BITS      (OFFSET_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_if.func),
    .in_row_offset    (in_if.row_offset),
    .in_final         (in_if.final_offset),
    .in_read_index    (in_if.read_index),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_row_number   (out_if.row_number),
    .out_group_length (out_if.group_length),
    .out_group_begin  (out_if.group_begin),
    .out_groups_total (out_if.groups_total),
    .out_status       (out_if.status)
  );

  assign in_if.ready = rdy;

endmodule

FILE: verif/rlcs_tb_if.sv
`timescale 1ns / 1ps
// Channels come from the RTL interfaces; this file holds the request and
// result records that the bench uses on both sides.
package rlcs_tb_pkg;
  import rlcs_pkg::*;

  typedef struct packed {
    logic [1:0]  func;
    logic [19:0] row_offset;
    logic        final_offset;
    logic [10:0] read_index;
  } request_t;

  typedef struct packed {
    logic [9:0]  row_number;
    logic [8:0]  group_length;
    logic [10:0] group_begin;
    logic [8:0]  groups_total;
    logic [1:0]  status;
  } answer_t;
endpackage

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rlcs_pkg::*;
  import rlcs_tb_pkg::*;

  localparam int NROWS = 1024;
  localparam int NLEN  = 256;
  localparam int NBKT  = NLEN + 1;
  localparam int STALL_LIMIT = 20000;
  localparam int ITEMS = 1250;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rlcs_in_if  in_ch ();
  rlcs_out_if out_ch ();

  row_length_counting_sort_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [19:0] prev_off;
  int          rows_in;
  logic [8:0]  row_len [NROWS];
  logic [9:0]  order [NROWS];
  logic [8:0]  grp_len [NBKT];
  logic [10:0] grp_start [NBKT + 1];
  int          grp_count;
  bit          sorted, load_bad, load_active;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int       errors = 0;
  int       sent = 0;
  bit       stim_done = 0;
  bit       hold_for_drain = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Counting sort of the loaded rows by length
  function automatic void sort_rows();
    int cnt [NBKT];
    int fill [NBKT];
    int pos, n;
    for (int k = 0; k < NBKT; k++) cnt[k] = 0;
    for (int k = 0; k < rows_in; k++) cnt[row_len[k]]++;
    pos = 0;
    n = 0;
    for (int k = 0; k < NBKT; k++) begin
      fill[k] = pos;
      if (cnt[k] > 0) begin
        grp_len[n] = 9'(k);
        grp_start[n] = 11'(pos);
        n++;
        pos += cnt[k];
      end
    end
    grp_start[n] = 11'(pos);
    grp_count = n;
    for (int k = 0; k < rows_in; k++) begin
      order[fill[row_len[k]]] = 10'(k);
      fill[row_len[k]]++;
    end
    sorted = 1;
  endfunction

  function automatic void predict(input request_t r);
    answer_t a;
    int len;
    a = '0;
    if (r.func == FN_LOAD) begin
      if (!load_active) begin
        load_active = 1;
        sorted = 0;
        load_bad = 0;
        rows_in = 0;
        grp_count = 0;
      end else if (r.row_offset < prev_off) begin
        load_bad = 1;
      end else begin
        len = int'(r.row_offset - prev_off);
        if (len > NLEN || rows_in >= NROWS) load_bad = 1;
        else row_len[rows_in++] = 9'(len);
      end
      prev_off = r.row_offset;
      if (!r.final_offset) return;
      load_active = 0;
      if (load_bad) begin
        grp_count = 0;
        a.group_begin = 11'(rows_in);
        a.status = ST_LOAD_ERR;
      end else begin
        sort_rows();
        a.group_begin = 11'(rows_in);
        a.groups_total = 9'(grp_count);
        a.status = ST_OK;
      end
      expected_answers.push_back(a);
      return;
    end
    if (r.func != FN_PERM && r.func != FN_GROUP) return;
    if (load_bad) a.status = ST_LOAD_ERR;
    else if (!sorted) a.status = ST_RANGE;
    else begin
      a.groups_total = 9'(grp_count);
      if (r.func == FN_PERM) begin
        if (r.read_index < rows_in) a.row_number = order[r.read_index];
        else a.status = ST_RANGE;
      end else if (r.read_index < grp_count) begin
        a.group_length = grp_len[r.read_index];
        a.group_begin = grp_start[r.read_index];
      end else if (r.read_index == grp_count) begin
        a.group_begin = grp_start[grp_count];
      end else begin
        a.status = ST_RANGE;
      end
    end
    expected_answers.push_back(a);
  endfunction

  // Stimulus builders
  function automatic request_t mk(input logic [1:0] f, input logic [19:0] off,
                                  input logic fin, input logic [10:0] idx);
    request_t r;
    r.func = f;
    r.row_offset = off;
    r.final_offset = fin;
    r.read_index = idx;
    return r;
  endfunction

  // Queue a load: start offset then one offset per row; kind 1 falls, 2 too long
  task automatic queue_matrix(input int nrows, input int maxlen, input int kind);
    logic [19:0] off;
    off = 20'($urandom);
    pending_reqs.push_back(mk(FN_LOAD, off, nrows == 0, 11'($urandom)));
    for (int i = 0; i < nrows; i++) begin
      off = off + 20'($urandom_range(0, maxlen));
      if (i == nrows / 2 && kind == 1) off = off - 20'd1 - 20'($urandom_range(0, 5));
      if (i == nrows / 2 && kind == 2) off = off + 20'(NLEN + 1);
      pending_reqs.push_back(mk(FN_LOAD, off, i == nrows - 1, 11'($urandom)));
    end
  endtask

  task automatic queue_reads(input int n, input int rows, input int groups);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: pending_reqs.push_back(mk(FN_UNUSED, 20'($urandom), 1'($urandom),
                                     11'($urandom)));
        1, 2, 3, 4: pending_reqs.push_back(mk(FN_PERM, 20'($urandom), 1'($urandom),
                                              11'($urandom_range(0, rows + 1))));
        5: pending_reqs.push_back(mk(FN_PERM, 20'($urandom), 1'($urandom),
                                     11'($urandom)));
        6: pending_reqs.push_back(mk(FN_GROUP, 20'($urandom), 1'($urandom),
                                     11'($urandom)));
        default: pending_reqs.push_back(mk(FN_GROUP, 20'($urandom), 1'($urandom),
                                           11'($urandom_range(0, groups + 1))));
      endcase
    end
  endtask

  // Driver
  int gap_in = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the request
    end else begin
      if (in_ch.valid) begin
        predict(request_t'({in_ch.func, in_ch.row_offset,
                            in_ch.final_offset, in_ch.read_index}));
        sent++;
      end
      if (gap_in > 0) begin
        gap_in <= gap_in - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0 &&
                   !(hold_for_drain && expected_answers.size() > 0)) begin
        request_t r;
        r = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func <= r.func;
        in_ch.row_offset <= r.row_offset;
        in_ch.final_offset <= r.final_offset;
        in_ch.read_index <= r.read_index;
        gap_in <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor
  int gap_out = 0;
  int quiet = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_answers.size() == 0) begin
          report("unexpected result", out_ch.status, 0);
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (out_ch.row_number !== e.row_number)
            report("row_number", out_ch.row_number, e.row_number);
          if (out_ch.group_length !== e.group_length)
            report("group_length", out_ch.group_length, e.group_length);
          if (out_ch.group_begin !== e.group_begin)
            report("group_begin", out_ch.group_begin, e.group_begin);
          if (out_ch.groups_total !== e.groups_total)
            report("groups_total", out_ch.groups_total, e.groups_total);
          if (out_ch.status !== e.status)
            report("status", out_ch.status, e.status);
        end
      end
      // draw the stall length per result
      if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid && out_ch.ready && $urandom_range(0, 3) == 0)
          gap_out <= $urandom_range(0, 10);
      end
      // watchdog on accepted requests and results
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FN_LOAD;
    in_ch.row_offset = '0;
    in_ch.final_offset = 1'b0;
    in_ch.read_index = '0;
    out_ch.ready = 1'b0;
    prev_off = '0;
    rows_in = 0;
    grp_count = 0;
    sorted = 0;
    load_bad = 0;
    load_active = 0;

    // directed: reads before any build, zero-row matrix, extremes
    pending_reqs.push_back(mk(FN_PERM, '0, 1'b0, '0));
    pending_reqs.push_back(mk(FN_GROUP, '1, 1'b1, 11'd1024));
    pending_reqs.push_back(mk(FN_UNUSED, '1, 1'b1, '1));
    pending_reqs.push_back(mk(FN_LOAD, 20'hFFFFF, 1'b1, '0));
    pending_reqs.push_back(mk(FN_GROUP, '0, 1'b0, '0));
    pending_reqs.push_back(mk(FN_GROUP, '0, 1'b0, 11'd1));
    pending_reqs.push_back(mk(FN_PERM, '0, 1'b0, '0));
    // rows of length 0 and 255 near the top of the offset range
    pending_reqs.push_back(mk(FN_LOAD, 20'hFFF00, 1'b0, '0));
    pending_reqs.push_back(mk(FN_LOAD, 20'hFFF00, 1'b0, '0));
    pending_reqs.push_back(mk(FN_LOAD, 20'hFFFFF, 1'b0, '0));
    pending_reqs.push_back(mk(FN_LOAD, 20'hFFFFF, 1'b0, '0));
    pending_reqs.push_back(mk(FN_LOAD, 20'hFFFFF, 1'b1, '0));
    for (int i = 0; i < 4; i++) pending_reqs.push_back(mk(FN_PERM, '0, 1'b0, 11'(i)));
    for (int i = 0; i < 4; i++) pending_reqs.push_back(mk(FN_GROUP, '0, 1'b0, 11'(i)));
    // falling offset, then row one too long
    pending_reqs.push_back(mk(FN_LOAD, 20'd50, 1'b0, '0));
    pending_reqs.push_back(mk(FN_LOAD, 20'd40, 1'b1, '0));
    pending_reqs.push_back(mk(FN_PERM, '0, 1'b0, '0));
    pending_reqs.push_back(mk(FN_LOAD, 20'd0, 1'b0, '0));
    pending_reqs.push_back(mk(FN_LOAD, 20'd257, 1'b1, '0));
    pending_reqs.push_back(mk(FN_GROUP, '0, 1'b0, '0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // one full-size load at the row limit
    queue_matrix(NROWS, NLEN, 0);
    queue_reads(30, NROWS, NBKT);

    // pause the sender until all results are back
    wait (pending_reqs.size() == 0 && !in_ch.valid);
    hold_for_drain = 1;
    wait (expected_answers.size() == 0);
    hold_for_drain = 0;

    // random sessions, mostly small and well formed
    while (sent + pending_reqs.size() < ITEMS) begin
      int n, g;
      n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom_range(1, 24);
      g = $urandom_range(0, 5) == 0 ? NLEN : $urandom_range(0, 6);
      queue_matrix(n, g, $urandom_range(0, 7) == 0 ? $urandom_range(1, 2) : 0);
      queue_reads($urandom_range(2, 20), n, n);
      if ($urandom_range(0, 9) == 0)
        pending_reqs.push_back(mk(FN_LOAD, 20'($urandom), 1'b0, '0));
      // pause the sender until all results are back
      if ($urandom_range(0, 15) == 0) begin
        wait (pending_reqs.size() == 0 && !in_ch.valid);
        hold_for_drain = 1;
        wait (expected_answers.size() == 0);
        hold_for_drain = 0;
      end
    end

    wait (pending_reqs.size() == 0 && !in_ch.valid);
    wait (expected_answers.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
